// ===== sv/stbm_pkg.sv =====
`timescale 1ns / 1ps

package stbm_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHECK_PERIOD = 2'd0;
  localparam logic [1:0] CFG_FALL_COUNT   = 2'd1;
  localparam logic [1:0] CFG_RISE_COUNT   = 2'd2;

  localparam logic [7:0] CHECK_PERIOD_RST = 8'd10;
  localparam logic [7:0] FALL_COUNT_RST   = 8'd5;
  localparam logic [7:0] RISE_COUNT_RST   = 8'd10;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  // Comparator threshold codes; code 3 is illegal
  localparam logic [1:0] THR_4V2 = 2'd0;
  localparam logic [1:0] THR_3V9 = 2'd1;
  localparam logic [1:0] THR_3V6 = 2'd2;
  localparam logic [1:0] THR_BAD = 2'd3;

  // Battery level codes
  localparam logic [1:0] LVL_4V2 = 2'd0;
  localparam logic [1:0] LVL_3V9 = 2'd1;
  localparam logic [1:0] LVL_3V6 = 2'd2;
  localparam logic [1:0] LVL_3V0 = 2'd3;

  typedef struct packed {
    logic [7:0] check_period;
    logic [7:0] fall_count;
    logic [7:0] rise_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] prescaler;
    logic [7:0] count;
    logic [1:0] thr;
    logic [1:0] lvl;
  } state_t;

  typedef struct packed {
    logic tick;
    logic below_threshold;
  } item_t;

  typedef struct packed {
    logic [1:0] threshold_select;
    logic [1:0] battery_level;
    logic       clear_flag;
    logic       blue_lamp;
    logic       red_lamp;
  } result_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 8'd1;
  endfunction

endpackage

// ===== sv/stbm_in_if.sv =====
`timescale 1ns / 1ps

interface stbm_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic below_threshold;

  modport source (output valid, tick, below_threshold, input ready);
  modport sink (input valid, tick, below_threshold, output ready);
endinterface

// ===== sv/stbm_out_if.sv =====
`timescale 1ns / 1ps

interface stbm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] threshold_select;
  logic [1:0] battery_level;
  logic       clear_flag;
  logic       blue_lamp;
  logic       red_lamp;

  modport source (output valid, threshold_select, battery_level, clear_flag, blue_lamp,
                  red_lamp, input ready);
  modport sink (input valid, threshold_select, battery_level, clear_flag, blue_lamp,
                red_lamp, output ready);
endinterface

// ===== sv/stbm_cfg.sv =====
`timescale 1ns / 1ps

module stbm_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  output stbm_pkg::cfg_t     cfg_o
);

  stbm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_period <= stbm_pkg::CHECK_PERIOD_RST;
      cfg_q.fall_count   <= stbm_pkg::FALL_COUNT_RST;
      cfg_q.rise_count   <= stbm_pkg::RISE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stbm_pkg::CFG_CHECK_PERIOD: cfg_q.check_period <= cfg_wdata_i;
        stbm_pkg::CFG_FALL_COUNT:   cfg_q.fall_count   <= cfg_wdata_i;
        stbm_pkg::CFG_RISE_COUNT:   cfg_q.rise_count   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/stbm_update.sv =====
`timescale 1ns / 1ps

module stbm_update (
  input  stbm_pkg::cfg_t    cfg_i,
  input  stbm_pkg::state_t  state_i,
  input  stbm_pkg::item_t   item_i,
  output stbm_pkg::state_t  state_o,
  output stbm_pkg::result_t result_o
);

  logic [7:0] pre_inc;
  logic [7:0] cnt_inc;
  logic       sample;
  logic       clr;

  always_comb begin
    pre_inc = stbm_pkg::sat_inc(state_i.prescaler);
    cnt_inc = stbm_pkg::sat_inc(state_i.count);
    sample  = item_i.tick && (pre_inc >= cfg_i.check_period);
    state_o = state_i;
    clr     = 1'b0;

    if (item_i.tick) begin
      state_o.prescaler = sample ? 8'd0 : pre_inc;
    end

    if (sample) begin
      if (state_i.thr == stbm_pkg::THR_BAD) begin
        // recover to the top threshold, leave count and level
        state_o.thr = stbm_pkg::THR_4V2;
      end else begin
        state_o.count = cnt_inc;
        if (item_i.below_threshold) begin
          clr = 1'b1;
          if (cnt_inc >= cfg_i.fall_count) begin
            state_o.count = 8'd0;
            case (state_i.thr)
              stbm_pkg::THR_4V2: begin
                state_o.lvl = stbm_pkg::LVL_3V9;
                state_o.thr = stbm_pkg::THR_3V9;
              end
              stbm_pkg::THR_3V9: begin
                state_o.lvl = stbm_pkg::LVL_3V6;
                state_o.thr = stbm_pkg::THR_3V6;
              end
              default: state_o.lvl = stbm_pkg::LVL_3V0;
            endcase
          end
        end else if (cnt_inc >= cfg_i.rise_count) begin
          state_o.count = 8'd0;
          case (state_i.thr)
            stbm_pkg::THR_4V2: state_o.lvl = stbm_pkg::LVL_4V2;
            stbm_pkg::THR_3V9: begin
              state_o.thr = stbm_pkg::THR_4V2;
              state_o.lvl = stbm_pkg::LVL_3V9;
            end
            default: begin
              state_o.thr = stbm_pkg::THR_3V9;
              state_o.lvl = stbm_pkg::LVL_3V6;
            end
          endcase
        end
      end
    end

    result_o.threshold_select = state_o.thr;
    result_o.battery_level    = state_o.lvl;
    result_o.clear_flag       = clr;
    result_o.blue_lamp        = (state_o.lvl == stbm_pkg::LVL_4V2) ||
                                (state_o.lvl == stbm_pkg::LVL_3V9);
    result_o.red_lamp         = (state_o.lvl == stbm_pkg::LVL_4V2) ||
                                (state_o.lvl == stbm_pkg::LVL_3V6);
  end

endmodule

// ===== sv/stepped_threshold_battery_monitor.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                              Transfer
// in_i      in   tick, below_threshold                                valid & ready
// out_o     out  threshold_select, battery_level, clear_flag, lamps   valid & ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i                     cfg_we_i high
//
// One result per input item; an item is held in the input register and moves into
// the result register when that slot frees up.
// Throughput is one item per cycle while the output is not stalled, set by the
// single state update between the input and result registers. Reset clears the
// state, the counters and both valid flags, and loads the register defaults. A
// stalled output holds the result and the input register; input stays ready while
// the input register is empty or drains this cycle.

module stepped_threshold_battery_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  stbm_in_if.sink    in_i,
  stbm_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  stbm_pkg::cfg_t    cfg;
  stbm_pkg::state_t  state_q;
  stbm_pkg::state_t  state_d;
  stbm_pkg::item_t   item_q;
  stbm_pkg::result_t res_d;
  stbm_pkg::result_t res_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_ready;

  stbm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  stbm_update u_update (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // move the held item into the result register when that slot frees up
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      item_q.tick            <= in_i.tick;
      item_q.below_threshold <= in_i.below_threshold;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.threshold_select = res_q.threshold_select;
  assign out_o.battery_level    = res_q.battery_level;
  assign out_o.clear_flag       = res_q.clear_flag;
  assign out_o.blue_lamp        = res_q.blue_lamp;
  assign out_o.red_lamp         = res_q.red_lamp;

endmodule
